// ----- src/tar_header_checker_assert.svh -----
// Assertion helpers for the tar header checker.
// Both macros compile away when SYNTHESIS is defined.
`ifndef TAR_HEADER_CHECKER_ASSERT_SVH
`define TAR_HEADER_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop on every rising edge outside reset.
`define THC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tar header checker assertion failed");

// Check prop on every rising edge, reset included.
`define THC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tar header checker assertion failed");

`else

`define THC_ASSERT(lbl, clk, rst_n, prop)
`define THC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- src/thc_pkg.sv -----
`default_nettype none

package thc_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned SUM_BYTES   = 500;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned SUM_W       = 17;
    localparam int unsigned ACC_W       = 36;
    localparam int unsigned ID_W        = 24;
    localparam int unsigned CHK_FIRST   = 148;
    localparam int unsigned CHK_LAST    = 155;
    localparam int unsigned TYPE_POS    = 156;
    localparam int unsigned MAGIC_POS   = 257;
    localparam int unsigned MAGIC_LEN   = 5;
    // eight blanks stand in for the chksum field
    localparam logic [SUM_W-1:0] BLANK_SUM = SUM_W'(8 * 32);

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_MAGIC  = 2'd1,
        ERR_SUM    = 2'd2,
        ERR_DIGITS = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2,
        PH_EMPTY  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        FLD_MODE  = 3'd0,
        FLD_UID   = 3'd1,
        FLD_GID   = 3'd2,
        FLD_SIZE  = 3'd3,
        FLD_MTIME = 3'd4,
        FLD_CHK   = 3'd5,
        FLD_NONE  = 3'd6
    } t_fld;

    // one header beat as it leaves the input register
    typedef struct packed {
        logic       fire;
        logic       last;
        t_pos       pos;
        logic [7:0] data;
    } t_step;

    typedef struct packed {
        logic [ID_W-1:0]  mode;
        logic [ID_W-1:0]  uid;
        logic [ID_W-1:0]  gid;
        logic [ACC_W-1:0] size;
        logic [ACC_W-1:0] mtime;
        logic [ID_W-1:0]  chksum;
        logic             number_bad;
        logic             chk_bad;
    } t_fields;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             magic_ok;
        logic [7:0]       type_byte;
    } t_sum_st;

    function automatic logic in_range(t_pos pos, int unsigned lo, int unsigned hi);
        return (pos >= t_pos'(lo)) && (pos <= t_pos'(hi));
    endfunction

    function automatic t_fld field_of(t_pos pos);
        t_fld f;
        f = FLD_NONE;
        if (in_range(pos, 100, 107))      f = FLD_MODE;
        else if (in_range(pos, 108, 115)) f = FLD_UID;
        else if (in_range(pos, 116, 123)) f = FLD_GID;
        else if (in_range(pos, 124, 135)) f = FLD_SIZE;
        else if (in_range(pos, 136, 147)) f = FLD_MTIME;
        else if (in_range(pos, CHK_FIRST, CHK_LAST)) f = FLD_CHK;
        return f;
    endfunction

    function automatic logic field_first(t_pos pos);
        return (pos == t_pos'(100)) || (pos == t_pos'(108)) || (pos == t_pos'(116)) ||
               (pos == t_pos'(124)) || (pos == t_pos'(136)) || (pos == t_pos'(CHK_FIRST));
    endfunction

    function automatic logic field_last(t_pos pos);
        return (pos == t_pos'(107)) || (pos == t_pos'(115)) || (pos == t_pos'(123)) ||
               (pos == t_pos'(135)) || (pos == t_pos'(147)) || (pos == t_pos'(CHK_LAST));
    endfunction

    function automatic logic [7:0] magic_char(logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h75; // u
            3'd1:    c = 8'h73; // s
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h61; // a
            3'd4:    c = 8'h72; // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/thc_sum.sv -----
`default_nettype none

module thc_sum
    import thc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_step   i_step,
    output t_sum_st      o_st
);

    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_magic, n_magic;
    logic [7:0]       r_type, n_type;
    t_pos             w_moff;

    assign w_moff = i_step.pos - t_pos'(MAGIC_POS);

    always_comb begin
        n_sum   = r_sum;
        n_magic = r_magic;
        n_type  = r_type;
        if (i_step.fire) begin
            if (i_step.last) begin
                n_sum   = BLANK_SUM;
                n_magic = 1'b1;
                n_type  = '0;
            end else begin
                // skip the chksum field, it is already counted as blanks
                if ((i_step.pos < t_pos'(SUM_BYTES)) &&
                    !in_range(i_step.pos, CHK_FIRST, CHK_LAST)) begin
                    n_sum = r_sum + SUM_W'(i_step.data);
                end
                if (in_range(i_step.pos, MAGIC_POS, MAGIC_POS + MAGIC_LEN - 1) &&
                    (i_step.data != magic_char(w_moff[2:0]))) begin
                    n_magic = 1'b0;
                end
                if (i_step.pos == t_pos'(TYPE_POS)) begin
                    n_type = i_step.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= BLANK_SUM;
            r_magic <= 1'b1;
            r_type  <= '0;
        end else begin
            r_sum   <= n_sum;
            r_magic <= n_magic;
            r_type  <= n_type;
        end
    end

    assign o_st.sum       = r_sum;
    assign o_st.magic_ok  = r_magic;
    assign o_st.type_byte = r_type;

endmodule

`default_nettype wire

// ----- src/thc_octal.sv -----
`default_nettype none

module thc_octal
    import thc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_step i_step,
    output t_fields    o_fields
);

    logic [ACC_W-1:0] r_acc, n_acc, w_acc_in, w_value;
    t_phase           r_phase, n_phase, w_ph_in;
    t_fields          r_fld, n_fld;
    t_fld             w_fld;
    logic             w_digit, w_first, w_empty;

    assign w_fld   = field_of(i_step.pos);
    assign w_first = field_first(i_step.pos);
    assign w_digit = (i_step.data[7:3] == 5'b00110);

    always_comb begin
        n_acc   = r_acc;
        n_phase = r_phase;
        n_fld   = r_fld;
        w_empty = 1'b0;
        w_value = '0;
        // restart the parse on the first byte of each field
        w_acc_in = w_first ? '0 : r_acc;
        w_ph_in  = w_first ? PH_LEAD : r_phase;
        if (i_step.fire && i_step.last) begin
            n_acc   = '0;
            n_phase = PH_LEAD;
            n_fld   = '0;
        end else if (i_step.fire && (w_fld != FLD_NONE)) begin
            n_acc   = w_acc_in;
            n_phase = w_ph_in;
            unique case (w_ph_in)
                PH_LEAD: begin
                    if (w_digit) begin
                        n_acc   = ACC_W'(i_step.data[2:0]);
                        n_phase = PH_DIGITS;
                    end else if (i_step.data != 8'h20) begin
                        n_phase = PH_EMPTY;
                    end
                end
                PH_DIGITS: begin
                    if (w_digit) begin
                        n_acc = {w_acc_in[ACC_W-4:0], i_step.data[2:0]};
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
            if (field_last(i_step.pos)) begin
                w_empty = (n_phase == PH_LEAD) || (n_phase == PH_EMPTY);
                w_value = w_empty ? '0 : n_acc;
                case (w_fld)
                    FLD_MODE:  n_fld.mode   = w_value[ID_W-1:0];
                    FLD_UID:   n_fld.uid    = w_value[ID_W-1:0];
                    FLD_GID:   n_fld.gid    = w_value[ID_W-1:0];
                    FLD_SIZE:  n_fld.size   = w_value;
                    FLD_MTIME: n_fld.mtime  = w_value;
                    default:   n_fld.chksum = w_value[ID_W-1:0];
                endcase
                if (w_empty) begin
                    if (w_fld == FLD_CHK) n_fld.chk_bad = 1'b1;
                    else                  n_fld.number_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_phase <= PH_LEAD;
            r_fld   <= '0;
        end else begin
            r_acc   <= n_acc;
            r_phase <= n_phase;
            r_fld   <= n_fld;
        end
    end

    assign o_fields = r_fld;

endmodule

`default_nettype wire

// ----- src/tar_header_checker.sv -----
// tar_header_checker: validates one 512-byte ustar header that arrives as 512
// byte beats on the input channel, and gives one result beat per header. Every
// beat is caught in an input register and is folded into the running state by
// short logic (one 17-bit add, a magic byte compare and a 3-bit octal shift
// into a 36-bit accumulator), so the block takes one byte per cycle unless a
// result waits. The result lands in an output register as the last header byte
// leaves the input register; the input side only stalls while the last byte of
// the next header waits for an untaken result. The result carries the
// unsigned sum over bytes 0..499 (chksum field counted as blanks), the magic
// and octal checks folded into an error code (bad magic first, then a chksum
// field without digits, then a checksum mismatch, then any other field without
// digits), and the parsed mode, uid, gid, size, mtime and the raw type flag,
// which read as zero whenever the header is not valid. State returns to its
// reset values after each header, so headers may follow back to back.
`default_nettype none

module tar_header_checker
    import thc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_header_ok,
    output logic [1:0]             o_error_code,
    output logic [ACC_W-1:0]       o_entry_size,
    output logic [ID_W-1:0]        o_file_mode,
    output logic [ID_W-1:0]        o_owner_id,
    output logic [ID_W-1:0]        o_group_id,
    output logic [ACC_W-1:0]       o_mod_time,
    output logic [7:0]             o_type_flag,
    output logic [SUM_W-1:0]       o_computed_sum
);

`include "tar_header_checker_assert.svh"

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_pos       r_pos;

    // result register
    logic             r_out_valid;
    logic             r_ok;
    t_err             r_err;
    logic [ACC_W-1:0] r_size, r_mtime;
    logic [ID_W-1:0]  r_mode, r_uid, r_gid;
    logic [7:0]       r_type;
    logic [SUM_W-1:0] r_sum;

    t_step   w_step;
    t_fields w_fields;
    t_sum_st w_sum;
    logic    w_last, w_proc, w_accept;
    t_err    w_err;

    assign w_last = (r_pos == t_pos'(BLOCK_BYTES - 1));
    // advance the held beat unless it finishes a header while the result waits
    assign w_proc   = r_in_valid && (!w_last || !r_out_valid || i_ready);
    assign o_ready  = !r_in_valid || w_proc;
    assign w_accept = i_valid && o_ready;

    assign w_step.fire = w_proc;
    assign w_step.last = w_last;
    assign w_step.pos  = r_pos;
    assign w_step.data = r_in_byte;

    thc_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_st    (w_sum)
    );

    thc_octal u_octal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_fields (w_fields)
    );

    // the last byte touches no field, so the verdict comes from held state
    always_comb begin
        if (!w_sum.magic_ok) begin
            w_err = ERR_MAGIC;
        end else if (w_fields.chk_bad) begin
            w_err = ERR_DIGITS;
        end else if (ID_W'(w_sum.sum) != w_fields.chksum) begin
            w_err = ERR_SUM;
        end else if (w_fields.number_bad) begin
            w_err = ERR_DIGITS;
        end else begin
            w_err = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_pos <= w_last ? '0 : r_pos + t_pos'(1);
            end
            if (w_proc && w_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: hold the byte and the result until they move on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_data_byte;
        end
        if (w_proc && w_last) begin
            r_ok    <= (w_err == ERR_NONE);
            r_err   <= w_err;
            r_sum   <= w_sum.sum;
            r_size  <= (w_err == ERR_NONE) ? w_fields.size  : '0;
            r_mtime <= (w_err == ERR_NONE) ? w_fields.mtime : '0;
            r_mode  <= (w_err == ERR_NONE) ? w_fields.mode  : '0;
            r_uid   <= (w_err == ERR_NONE) ? w_fields.uid   : '0;
            r_gid   <= (w_err == ERR_NONE) ? w_fields.gid   : '0;
            r_type  <= (w_err == ERR_NONE) ? w_sum.type_byte : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_header_ok    = r_ok;
    assign o_error_code   = r_err;
    assign o_entry_size   = r_size;
    assign o_file_mode    = r_mode;
    assign o_owner_id     = r_uid;
    assign o_group_id     = r_gid;
    assign o_mod_time     = r_mtime;
    assign o_type_flag    = r_type;
    assign o_computed_sum = r_sum;

    // a new result only follows the last byte of a header
    `THC_ASSERT(a_result_after_last, i_clk, i_rst_n, $rose(o_valid) |-> $past(w_proc && w_last))
    // ok flag and error code agree
    `THC_ASSERT(a_ok_matches_err, i_clk, i_rst_n,
                o_valid |-> (o_header_ok == (o_error_code == ERR_NONE)))
    // size and type flag of a bad header read as zero
    `THC_ASSERT(a_bad_fields_zero, i_clk, i_rst_n,
                (o_valid && !o_header_ok) |-> (o_entry_size == '0 && o_type_flag == '0))
    // the input side only stalls on a full input register
    `THC_ASSERT(a_stall_needs_beat, i_clk, i_rst_n,
                !o_ready |-> (r_in_valid && w_last && r_out_valid))
    // the byte counter wraps only after a header completes
    `THC_ASSERT(a_pos_wrap, i_clk, i_rst_n,
                (r_pos == '0 && $past(r_pos) != '0) |-> $past(w_proc && w_last))

endmodule

`default_nettype wire
